>>> rtl/core/mirg_pkg.sv
// package for the mixed io request generator
// shared types, constants and the front-to-back command struct
package mirg_pkg;
    localparam int NUM_SIZES_DEF   = 13;
    localparam int OFFSET_BITS_DEF = 48;
    localparam int FILE_W  = 48;
    localparam int IDX_W   = 4;
    localparam int SIZE_W  = 22;
    localparam int WORD_W  = 64;
    localparam int CFG_W   = 48;
    localparam int CFG_IDX_W = 1;
    localparam logic [31:0] READ_LIMIT = 32'hBFFFFFFF;
    localparam logic [IDX_W-1:0] LOG_BASE = 4'd9;

    typedef enum logic [1:0] {
        ACT_GEN     = 2'd0,
        ACT_LD_RAND = 2'd1,
        ACT_LD_SEQ  = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [0:0] {
        CFG_FILE_SIZE = 1'b0,
        CFG_MIN_INDEX = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        KIND_RANDOM  = 2'd0,
        KIND_FWD     = 2'd1,
        KIND_BWD     = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_DIV   = 3'd1,
        ST_MOD   = 3'd2,
        ST_DONE  = 3'd3,
        ST_OUT   = 3'd4
    } t_state;

    typedef struct packed {
        logic              is_write;
        t_kind             kind;
        logic [IDX_W-1:0]  size_idx;
        logic [WORD_W-1:0] word;
    } t_cmd;
endpackage

>>> rtl/core/mirg_front.sv
// front end: takes transactions, loads threshold tables, classifies requests
// depends on mirg_pkg
module mirg_front
    import mirg_pkg::*;
#(
    parameter int NUM_SIZES = NUM_SIZES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_action,
    input  logic [WORD_W-1:0] i_random_word,
    input  logic [IDX_W-1:0]  i_table_index,
    input  logic [31:0]       i_table_value,
    input  logic [IDX_W-1:0]  i_min_idx,
    output logic              o_cmd_valid,
    input  logic              i_cmd_stall,
    output t_cmd              o_cmd
);
    logic [31:0] r_rand_tbl [NUM_SIZES];
    logic [31:0] r_seq_tbl  [NUM_SIZES];
    logic        r_full;
    t_cmd        r_cmd;
    logic        accept;
    logic [31:0] low, high;
    logic        wr, seq;
    logic [IDX_W-1:0] sel;

    assign o_stall     = r_full && i_cmd_stall;
    assign accept      = i_valid && !o_stall;
    assign o_cmd_valid = r_full;
    assign o_cmd       = r_cmd;
    assign low  = i_random_word[31:0];
    assign high = i_random_word[63:32];
    assign wr   = low > READ_LIMIT;
    assign seq  = wr ? (low[4:0] <= 5'd1) : (low[4:0] == 5'd0);

    always_comb begin
        sel = IDX_W'(NUM_SIZES - 1);
        for (int k = NUM_SIZES - 2; k >= 0; k--) begin
            if (IDX_W'(k) >= i_min_idx &&
                high < (seq ? r_seq_tbl[k] : r_rand_tbl[k])) begin
                sel = IDX_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && {1'b0, i_table_index} < (IDX_W + 1)'(NUM_SIZES)) begin
            if (i_action == ACT_LD_RAND) r_rand_tbl[i_table_index] <= i_table_value;
            if (i_action == ACT_LD_SEQ)  r_seq_tbl[i_table_index]  <= i_table_value;
        end
        if (accept && i_action == ACT_GEN) begin
            r_cmd.is_write <= wr;
            r_cmd.kind     <= !seq ? KIND_RANDOM : (low[0] ? KIND_FWD : KIND_BWD);
            r_cmd.size_idx <= sel;
            r_cmd.word     <= i_random_word;
        end
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (accept) begin
            r_full <= i_action == ACT_GEN;
        end else if (!i_cmd_stall) begin
            r_full <= 1'b0;
        end
    end
endmodule

>>> rtl/core/mirg_back.sv
// back end: walks sequential positions, runs the slot modulo bit-serially
// depends on mirg_pkg
module mirg_back
    import mirg_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_stall,
    input  t_cmd              i_cmd,
    input  logic [FILE_W-1:0] i_file_size,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_is_write,
    output logic [FILE_W-1:0] o_request_offset,
    output logic [SIZE_W-1:0] o_request_size,
    output logic              o_size_error
);
    localparam int CNT_W = $clog2(WORD_W + 1);
    localparam int SH_W  = $clog2(WORD_W);

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [OFFSET_BITS-1:0] r_rf, r_rb, r_wf, r_wb;
    logic [WORD_W-1:0] r_rem, r_q;
    logic [CNT_W-1:0]  r_cnt;
    logic [OFFSET_BITS-1:0] r_off;
    logic              r_err;
    logic [SH_W-1:0]   lsh;
    logic [WORD_W-1:0] size64, q_calc, rem_sh;
    logic [OFFSET_BITS-1:0] pos, pos_n, off_n, sz;
    logic [OFFSET_BITS:0] fsum;
    logic              load_out;

    assign lsh    = SH_W'(r_cmd.size_idx) + SH_W'(LOG_BASE);
    assign size64 = WORD_W'(1) << lsh;
    assign sz     = size64[OFFSET_BITS-1:0];
    assign q_calc = WORD_W'(i_file_size) >> lsh;
    assign rem_sh = {r_rem[WORD_W-2:0], r_cmd.word[WORD_W-1 - r_cnt[SH_W-1:0]]};

    always_comb begin
        pos = r_cmd.is_write ? (r_cmd.kind == KIND_FWD ? r_wf : r_wb)
                             : (r_cmd.kind == KIND_FWD ? r_rf : r_rb);
        fsum  = {1'b0, pos} + {1'b0, sz};
        pos_n = pos;
        off_n = pos;
        if (r_cmd.kind == KIND_FWD) begin
            if ((OFFSET_BITS + 1)'(i_file_size) < fsum) pos = '0;
            off_n = pos;
            pos_n = pos + sz;
        end else begin
            if (pos < sz) pos = OFFSET_BITS'(i_file_size);
            pos_n = pos - sz;
            off_n = pos_n;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_cmd_valid) n_state = ST_DIV;
            ST_DIV:  n_state = (r_cmd.kind == KIND_RANDOM && q_calc != '0) ? ST_MOD : ST_DONE;
            ST_MOD:  if (r_cnt == CNT_W'(WORD_W - 1)) n_state = ST_DONE;
            ST_DONE: n_state = ST_OUT;
            ST_OUT:  if (!o_valid || !i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_cmd_stall = r_state != ST_IDLE;
    assign load_out    = r_state == ST_DONE;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_cmd_valid) r_cmd <= i_cmd;
        if (r_state == ST_DIV) begin
            r_q   <= q_calc;
            r_rem <= '0;
            r_cnt <= '0;
            r_err <= r_cmd.kind == KIND_RANDOM && q_calc == '0;
            r_off <= r_cmd.kind == KIND_RANDOM ? '0 : off_n;
        end
        if (r_state == ST_MOD) begin
            r_rem <= (rem_sh >= r_q) ? rem_sh - r_q : rem_sh;
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(WORD_W - 1)) begin
                r_off <= OFFSET_BITS'(((rem_sh >= r_q) ? rem_sh - r_q : rem_sh) << lsh);
            end
        end
        if (load_out) begin
            o_is_write       <= r_cmd.is_write;
            o_request_offset <= FILE_W'(r_off);
            o_request_size   <= SIZE_W'(size64);
            o_size_error     <= r_err;
        end
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
            r_rf <= '0; r_rb <= '0; r_wf <= '0; r_wb <= '0;
        end else begin
            r_state <= n_state;
            if (load_out) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            if (r_state == ST_DIV && r_cmd.kind != KIND_RANDOM) begin
                case ({r_cmd.is_write, r_cmd.kind == KIND_FWD})
                    2'b00:   r_rb <= pos_n;
                    2'b01:   r_rf <= pos_n;
                    2'b10:   r_wb <= pos_n;
                    default: r_wf <= pos_n;
                endcase
            end
        end
    end
endmodule

>>> rtl/core/mixed_io_request_generator_unit.sv
// top level of the mixed io request generator: config registers, front, back
// depends on mirg_pkg, mirg_front, mirg_back
//   channel | direction | handshake           | payload
//   input   | in        | i_valid / o_stall   | action, random_word, table_index, table_value
//   output  | out       | o_valid / i_stall   | is_write, request_offset, request_size, size_error
//   config  | in        | i_cfg_we            | i_cfg_index, i_cfg_data
// a random request runs the bit-serial restoring modulo in the back end; sequential and
// failing requests skip it, and loads never leave the front end
// the one-entry queue lets the front take the next transaction while the back works
// reset is synchronous active low and clears positions and control state
// a stall on the output holds the result register and then the back end
module mixed_io_request_generator_unit
    import mirg_pkg::*;
#(
    parameter int NUM_SIZES   = NUM_SIZES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_action,
    input  logic [WORD_W-1:0]    i_random_word,
    input  logic [IDX_W-1:0]     i_table_index,
    input  logic [31:0]          i_table_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_is_write,
    output logic [FILE_W-1:0]    o_request_offset,
    output logic [SIZE_W-1:0]    o_request_size,
    output logic                 o_size_error
);
    // file size is kept within the position width
    localparam logic [FILE_W-1:0] FILE_MASK = (OFFSET_BITS >= FILE_W) ? {FILE_W{1'b1}}
                                            : FILE_W'((64'd1 << OFFSET_BITS) - 64'd1);

    logic [FILE_W-1:0] r_file_size;
    logic [IDX_W-1:0]  r_min_idx;
    logic cmd_valid, cmd_stall;
    t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size <= '0;
            r_min_idx   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FILE_SIZE: r_file_size <= i_cfg_data[FILE_W-1:0] & FILE_MASK;
                CFG_MIN_INDEX: r_min_idx   <= i_cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    mirg_front #(.NUM_SIZES(NUM_SIZES)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_action, .i_random_word,
        .i_table_index, .i_table_value, .i_min_idx(r_min_idx),
        .o_cmd_valid(cmd_valid), .i_cmd_stall(cmd_stall), .o_cmd(cmd)
    );

    mirg_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_stall(cmd_stall),
        .i_cmd(cmd), .i_file_size(r_file_size), .o_valid, .i_stall,
        .o_is_write, .o_request_offset, .o_request_size, .o_size_error
    );

`ifndef SYNTH
    a_err_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_size_error |-> o_request_offset == '0)
        else $error("size error with nonzero offset");
    a_size_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot(o_request_size))
        else $error("request size not a power of two");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_request_offset))
        else $error("stalled result changed");
`endif
endmodule

>>> bench/mixed_io_request_generator_unit_test.sv
// testbench for mixed_io_request_generator_unit: threshold loads, generate requests
// depends on mirg_pkg and the rtl; self-checking against a built-in request predictor
module mixed_io_request_generator_unit_test;
    import mirg_pkg::*;

    localparam int NSZ = NUM_SIZES_DEF;
    localparam logic [FILE_W-1:0] FILE_MAX = {FILE_W{1'b1}};

    typedef struct packed {
        logic              is_write;
        logic [FILE_W-1:0] offset;
        logic [SIZE_W-1:0] size;
        logic              err;
    } t_request;

    class request_scoreboard;
        logic [FILE_W-1:0] file_size;
        logic [IDX_W-1:0]  min_idx;
        logic [31:0]       rand_thr [NSZ];
        logic [31:0]       seq_thr [NSZ];
        logic [FILE_W-1:0] rd_fwd, rd_bwd, wr_fwd, wr_bwd;
        t_request          pending[$];
        int                errors;

        function void clear();
            file_size = '0;
            min_idx = '0;
            rd_fwd = '0;
            rd_bwd = '0;
            wr_fwd = '0;
            wr_bwd = '0;
            errors = 0;
            foreach (rand_thr[i]) begin
                rand_thr[i] = '0;
                seq_thr[i] = '0;
            end
        endfunction

        function logic [63:0] size_for(bit use_seq, logic [31:0] hi);
            int k;
            for (k = int'(min_idx); k < NSZ - 1; k++) begin
                if (hi < (use_seq ? seq_thr[k] : rand_thr[k]))
                    return 64'd512 << k;
            end
            return 64'd512 << (NSZ - 1);
        endfunction

        function void note_input(t_action act, logic [63:0] word, logic [IDX_W-1:0] idx,
                                 logic [31:0] val);
            t_request r;
            logic [31:0] lo;
            logic [63:0] sz, q, p;
            bit seq, fwd;
            if (act == ACT_LD_RAND || act == ACT_LD_SEQ) begin
                if (idx < NSZ) begin
                    if (act == ACT_LD_RAND) rand_thr[idx] = val;
                    else seq_thr[idx] = val;
                end
                return;
            end
            if (act != ACT_GEN) return;
            lo = word[31:0];
            r.is_write = lo > READ_LIMIT;
            seq = r.is_write ? (lo[4:0] <= 5'd1) : (lo[4:0] == 5'd0);
            fwd = lo[0];
            r.err = 1'b0;
            r.offset = '0;
            sz = size_for(seq, word[63:32]);
            if (seq) begin
                if (r.is_write) p = fwd ? {16'd0, wr_fwd} : {16'd0, wr_bwd};
                else p = fwd ? {16'd0, rd_fwd} : {16'd0, rd_bwd};
                if (fwd) begin
                    if (p + sz > {16'd0, file_size}) p = '0;
                    r.offset = p[FILE_W-1:0];
                    p = p + sz;
                end else begin
                    if (p < sz) p = {16'd0, file_size};
                    p = p - sz;
                    r.offset = p[FILE_W-1:0];
                end
                if (r.is_write) begin
                    if (fwd) wr_fwd = p[FILE_W-1:0]; else wr_bwd = p[FILE_W-1:0];
                end else begin
                    if (fwd) rd_fwd = p[FILE_W-1:0]; else rd_bwd = p[FILE_W-1:0];
                end
            end else begin
                q = {16'd0, file_size} / sz;
                if (q == 0) r.err = 1'b1;
                else begin
                    p = (word % q) * sz;
                    r.offset = p[FILE_W-1:0];
                end
            end
            r.size = sz[SIZE_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_result(t_request got);
            t_request want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, got %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.is_write !== want.is_write) begin
                $display("%0t: is_write expected %0h actual %0h", $time, want.is_write,
                         got.is_write);
                errors++;
            end
            if (got.offset !== want.offset) begin
                $display("%0t: offset expected %0h actual %0h", $time, want.offset,
                         got.offset);
                errors++;
            end
            if (got.size !== want.size) begin
                $display("%0t: size expected %0h actual %0h", $time, want.size, got.size);
                errors++;
            end
            if (got.err !== want.err) begin
                $display("%0t: size_error expected %0h actual %0h", $time, want.err,
                         got.err);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [1:0]           i_action = ACT_NONE;
    logic [WORD_W-1:0]    i_random_word = '0;
    logic [IDX_W-1:0]     i_table_index = '0;
    logic [31:0]          i_table_value = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_is_write;
    logic [FILE_W-1:0]    o_request_offset;
    logic [SIZE_W-1:0]    o_request_size;
    logic                 o_size_error;

    request_scoreboard sb = new();
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    int hold_rx = 0;

    mixed_io_request_generator_unit u_dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{o_is_write, o_request_offset, o_request_size, o_size_error});
    end

    // receiver stall process
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx > 0) begin
                i_stall <= 1'b1;
                repeat (hold_rx) @(negedge i_clk);
                hold_rx = 0;
            end
            if (rx_gaps && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 19);
                i_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send(t_action act, logic [63:0] word, logic [IDX_W-1:0] idx,
                        logic [31:0] val);
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_random_word <= word;
        i_table_index <= idx;
        i_table_value <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(act, word, idx, val);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_reg r, logic [CFG_W-1:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (r == CFG_FILE_SIZE) sb.file_size = d[FILE_W-1:0];
        else sb.min_idx = d[IDX_W-1:0];
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // sorted evenly spaced thresholds for both tables, or alternating extremes (inverted for the seq table)
    task automatic load_tables(bit extreme);
        logic [31:0] v;
        for (int k = 0; k < NSZ; k++) begin
            v = extreme ? (k[0] ? 32'hFFFFFFFF : 32'd0) : (32'hFFFFFFFF / NSZ) * (k + 1);
            send(ACT_LD_RAND, rand64(), k[IDX_W-1:0], v);
            send(ACT_LD_SEQ, rand64(), k[IDX_W-1:0], extreme ? ~v : v);
        end
    endtask

    function automatic logic [63:0] gen_word();
        logic [63:0] w = rand64();
        case ($urandom_range(0, 5))
            0: w[4:0] = 5'd0;
            1: begin w[31:30] = 2'b11; w[4:0] = 5'($urandom_range(0, 1)); end
            2: w[31:0] = READ_LIMIT;
            3: w[31:0] = READ_LIMIT + 32'd1;
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        logic [63:0] w;
        sb.clear();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part
        load_tables(1'b0);
        send(ACT_LD_RAND, '0, 4'd13, 32'h1234);
        send(ACT_LD_SEQ, '0, 4'd15, 32'hFFFFFFFF);
        send(ACT_NONE, '1, 4'd0, 32'd0);
        send(ACT_GEN, 64'd0, '0, '0);
        send(ACT_GEN, 64'hFFFFFFFF_FFFFFFFF, '0, '0);
        send(ACT_GEN, 64'h00000000_C0000001, '0, '0);
        send(ACT_GEN, 64'hFFFFFFFF_C0000000, '0, '0);
        drain();
        write_cfg(CFG_FILE_SIZE, 48'd1 << 24);
        write_cfg(CFG_MIN_INDEX, 48'd12);
        send(ACT_GEN, 64'h12345678_00000020, '0, '0);
        send(ACT_GEN, 64'h12345678_C0000001, '0, '0);
        send(ACT_GEN, 64'h12345678_C0000000, '0, '0);
        send(ACT_GEN, 64'h12345678_00000000, '0, '0);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: write_cfg(CFG_FILE_SIZE, FILE_MAX);
                1: write_cfg(CFG_FILE_SIZE, CFG_W'($urandom_range(0, 4096)));
                2: write_cfg(CFG_FILE_SIZE, CFG_W'({$urandom_range(0, 255), $urandom()}));
                default: write_cfg(CFG_FILE_SIZE, CFG_W'($urandom_range(1 << 20, 1 << 24)));
            endcase
            write_cfg(CFG_MIN_INDEX, ph == 7 ? CFG_W'(15) : CFG_W'($urandom_range(0, 12)));
            load_tables(ph == 3);
            if (ph == 6) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            if (ph == 2) hold_rx = 400;
            for (int n = 0; n < 110; n++) begin
                w = gen_word();
                case ($urandom_range(0, 19))
                    0: send(ACT_LD_RAND, w, IDX_W'($urandom_range(0, 15)), $urandom());
                    1: send(ACT_LD_SEQ, w, IDX_W'($urandom_range(0, 15)), $urandom());
                    2: send(ACT_NONE, w, IDX_W'($urandom_range(0, 15)), $urandom());
                    default: send(ACT_GEN, w, IDX_W'($urandom_range(0, 15)), $urandom());
                endcase
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

>>> mixed_io_request_generator_unit.f
rtl/core/mirg_pkg.sv
rtl/core/mirg_front.sv
rtl/core/mirg_back.sv
rtl/core/mixed_io_request_generator_unit.sv
bench/mixed_io_request_generator_unit_test.sv
